FILE: rtl/core/fanr_pkg.sv
package fanr_pkg;

  localparam int GUARD_BITS = 3;
  localparam int MANT_WIDTH = 64;

  localparam int IN_MANT_W = 64;
  localparam int IN_EXP_W = 13;
  localparam int OUT_W = 64;

  localparam int FW_W = 6;
  localparam int BIAS_W = 10;
  localparam int ALL_ONES_W = 11;
  localparam int EW_W = 4;

  localparam int FW_MIN = 1;
  localparam int FW_MAX = 52;

  localparam logic [FW_W-1:0] FW_RESET = 6'd52;
  localparam logic [BIAS_W-1:0] BIAS_RESET = 10'd1023;
  localparam logic [ALL_ONES_W-1:0] ALL_ONES_RESET = 11'd2047;
  localparam logic [EW_W-1:0] EW_RESET = 4'd11;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int NORM_W = (MANT_WIDTH > FW_MAX + GUARD_BITS + 1) ?
                          MANT_WIDTH : FW_MAX + GUARD_BITS + 1;
  localparam int SH_W = $clog2(NORM_W);
  localparam int LEAD_W = $clog2(MANT_WIDTH);
  localparam int EXP_W = 15;
  localparam int RND_W = NORM_W - GUARD_BITS;
  localparam int FRAC_W = FW_MAX + 1;
  localparam int POS_W = 7;

  typedef enum logic [1:0] {
    REG_FRACTION_WIDTH,
    REG_EXPONENT_BIAS,
    REG_EXPONENT_ALL_ONES,
    REG_EXPONENT_WIDTH
  } cfg_reg_t;

  typedef struct packed {
    logic [FW_W-1:0]       fw;
    logic [BIAS_W-1:0]     bias;
    logic [ALL_ONES_W-1:0] all_ones;
    logic [EW_W-1:0]       ew;
  } cfg_t;

  typedef struct packed {
    logic                    zero;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [NORM_W-1:0]       mant;
  } norm_t;

endpackage

FILE: rtl/core/fp_add_normalize_round_unit.sv
// Normalise and round-to-nearest-even stage for a floating-point adder. Each
// transaction carries an unrounded sum and yields one packed word in the
// format held in the four configuration registers. The datapath is a
// five-stage pipeline (leading-one search, exponent and shift distance,
// sticky shift, rounding, bias and pack): one transaction enters per cycle
// when the result side does not stall. A stall on the result side holds the
// whole pipeline, so the input then stalls in the same cycle. The user must
// write configuration only while the pipeline is empty; it is not enforced.
module fp_add_normalize_round_unit import fanr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_is_zero,
  input  logic                 in_sum_sign,
  input  logic [IN_EXP_W-1:0]  in_sum_exponent,
  input  logic [IN_MANT_W-1:0] in_sum_mantissa,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     out_packed_result,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [CFG_DW-1:0]    cfg_pwdata,
  output logic [CFG_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  cfg_t  cfg;
  logic  adv;
  logic  norm_valid;
  norm_t norm;

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  fanr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fanr_norm u_norm (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_is_zero      (in_is_zero),
    .in_sum_sign     (in_sum_sign),
    .in_sum_exponent (in_sum_exponent),
    .in_sum_mantissa (in_sum_mantissa),
    .norm_valid      (norm_valid),
    .norm            (norm)
  );

  fanr_round u_round (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .cfg               (cfg),
    .norm_valid        (norm_valid),
    .norm              (norm),
    .out_valid         (out_valid),
    .out_packed_result (out_packed_result)
  );

endmodule

FILE: rtl/core/fanr_cfg.sv
module fanr_cfg import fanr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [FW_W-1:0]       fw_r;
  logic [BIAS_W-1:0]     bias_r;
  logic [ALL_ONES_W-1:0] all_ones_r;
  logic [EW_W-1:0]       ew_r;
  logic                  wr_en;
  cfg_reg_t              idx;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= FW_RESET;
      bias_r     <= BIAS_RESET;
      all_ones_r <= ALL_ONES_RESET;
      ew_r       <= EW_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRACTION_WIDTH:    fw_r       <= cfg_pwdata[FW_W-1:0];
        REG_EXPONENT_BIAS:     bias_r     <= cfg_pwdata[BIAS_W-1:0];
        REG_EXPONENT_ALL_ONES: all_ones_r <= cfg_pwdata[ALL_ONES_W-1:0];
        REG_EXPONENT_WIDTH:    ew_r       <= cfg_pwdata[EW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      REG_FRACTION_WIDTH:    cfg_prdata = CFG_DW'(fw_r);
      REG_EXPONENT_BIAS:     cfg_prdata = CFG_DW'(bias_r);
      REG_EXPONENT_ALL_ONES: cfg_prdata = CFG_DW'(all_ones_r);
      REG_EXPONENT_WIDTH:    cfg_prdata = CFG_DW'(ew_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // clamp fraction width into the supported range
  always_comb begin
    cfg.fw = fw_r;
    if (fw_r < FW_W'(FW_MIN)) begin
      cfg.fw = FW_W'(FW_MIN);
    end else if (fw_r > FW_W'(FW_MAX)) begin
      cfg.fw = FW_W'(FW_MAX);
    end
    cfg.bias     = bias_r;
    cfg.all_ones = all_ones_r;
    cfg.ew       = ew_r;
  end

endmodule

FILE: rtl/core/fanr_norm.sv
module fanr_norm import fanr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  logic                in_is_zero,
  input  logic                in_sum_sign,
  input  logic [IN_EXP_W-1:0] in_sum_exponent,
  input  logic [IN_MANT_W-1:0] in_sum_mantissa,
  output logic                norm_valid,
  output norm_t               norm
);

  typedef struct packed {
    logic                    zero;
    logic                    sign;
    logic                    nz;
    logic signed [EXP_W-1:0] exp;
    logic [NORM_W-1:0]       mant;
    logic [LEAD_W-1:0]       lead;
  } s1_t;

  typedef struct packed {
    logic                    zero;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic signed [EXP_W-1:0] sh;
    logic [NORM_W-1:0]       mant;
  } s2_t;

  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  norm_t s3_r, s3_nxt;
  logic  v1_r, v2_r, v3_r;

  logic [MANT_WIDTH-1:0]   m_in;
  logic signed [EXP_W-1:0] lead_s, pos_s, emin, ef_cand, ef;
  logic signed [EXP_W-1:0] rs, ls;
  logic [NORM_W-1:0]       lost_mask;
  logic                    sticky;

  // leading one search
  always_comb begin
    m_in = in_sum_mantissa[MANT_WIDTH-1:0];
    s1_nxt.zero = in_is_zero;
    s1_nxt.sign = in_sum_sign;
    s1_nxt.nz   = |m_in;
    s1_nxt.exp  = EXP_W'($signed(in_sum_exponent));
    s1_nxt.mant = NORM_W'(m_in);
    s1_nxt.lead = '0;
    for (int i = 0; i < MANT_WIDTH; i++) begin
      if (m_in[i]) begin
        s1_nxt.lead = LEAD_W'(i);
      end
    end
  end

  // final exponent and shift distance
  always_comb begin
    lead_s  = EXP_W'(s1_r.lead);
    pos_s   = EXP_W'(cfg.fw) + EXP_W'(GUARD_BITS);
    emin    = EXP_W'(1) - EXP_W'(cfg.bias);
    ef_cand = s1_r.exp + lead_s - pos_s;
    if (!s1_r.nz || ef_cand < emin) begin
      ef = emin;
    end else begin
      ef = ef_cand;
    end
    s2_nxt.zero = s1_r.zero;
    s2_nxt.sign = s1_r.sign;
    s2_nxt.exp  = ef;
    s2_nxt.sh   = ef - s1_r.exp;
    s2_nxt.mant = s1_r.mant;
  end

  // shift left, or shift right with sticky
  always_comb begin
    rs = s2_r.sh;
    ls = -s2_r.sh;
    lost_mask = '0;
    sticky = 1'b0;
    s3_nxt.zero = s2_r.zero;
    s3_nxt.sign = s2_r.sign;
    s3_nxt.exp  = s2_r.exp;
    s3_nxt.mant = s2_r.mant;
    if (s2_r.sh < 0) begin
      s3_nxt.mant = s2_r.mant << ls[SH_W-1:0];
    end else if (rs >= EXP_W'(NORM_W)) begin
      s3_nxt.mant = NORM_W'(|s2_r.mant);
    end else begin
      lost_mask = ~({NORM_W{1'b1}} << rs[SH_W-1:0]);
      sticky = |(s2_r.mant & lost_mask);
      s3_nxt.mant = (s2_r.mant >> rs[SH_W-1:0]) | NORM_W'(sticky);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign norm_valid = v3_r;
  assign norm = s3_r;

endmodule

FILE: rtl/core/fanr_round.sv
module fanr_round import fanr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  cfg_t             cfg,
  input  logic             norm_valid,
  input  norm_t            norm,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_packed_result
);

  typedef struct packed {
    logic                    zero;
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [FRAC_W-1:0]       r;
  } s4_t;

  s4_t              s4_r, s4_nxt;
  logic             v4_r, v5_r;
  logic [OUT_W-1:0] res_r, res_nxt;

  logic [GUARD_BITS-1:0]   rbits;
  logic [RND_W-1:0]        r0;
  logic [RND_W:0]          r1, r2;
  logic                    inc, carry;
  logic signed [EXP_W-1:0] raw;
  logic [EXP_W-1:0]        bexp, emask;
  logic [OUT_W-1:0]        fmask, word;
  logic [POS_W-1:0]        spos;
  logic                    sub;

  // round to nearest even, renormalise on carry
  always_comb begin
    rbits = norm.mant[GUARD_BITS-1:0];
    r0    = norm.mant[NORM_W-1:GUARD_BITS];
    inc   = (rbits > GUARD_BITS'(1 << (GUARD_BITS - 1))) ||
            ((rbits == GUARD_BITS'(1 << (GUARD_BITS - 1))) && r0[0]);
    r1    = (RND_W+1)'(r0) + (RND_W+1)'(inc);
    carry = (r1 >> (cfg.fw + FW_W'(1))) != '0;
    r2    = carry ? (r1 >> 1) : r1;
    s4_nxt.zero = norm.zero;
    s4_nxt.sign = norm.sign;
    s4_nxt.exp  = carry ? norm.exp + EXP_W'(1) : norm.exp;
    s4_nxt.r    = r2[FRAC_W-1:0];
  end

  // bias, overflow and pack
  always_comb begin
    raw   = s4_r.exp + EXP_W'(cfg.bias);
    emask = ~({EXP_W{1'b1}} << cfg.ew);
    fmask = ~({OUT_W{1'b1}} << cfg.fw);
    sub   = (s4_r.r >> cfg.fw) == '0;
    spos  = POS_W'(cfg.fw) + POS_W'(cfg.ew);
    word  = '0;
    if (raw >= EXP_W'(cfg.all_ones)) begin
      bexp = EXP_W'(cfg.all_ones);
    end else if (raw <= 0 || sub) begin
      bexp = '0;
      word = OUT_W'(s4_r.r) & fmask;
    end else begin
      bexp = raw;
      word = OUT_W'(s4_r.r) & fmask;
    end
    word = word | (OUT_W'(bexp & emask) << cfg.fw);
    if (spos < POS_W'(OUT_W)) begin
      word = word | (OUT_W'(s4_r.sign) << spos);
    end
    res_nxt = s4_r.zero ? '0 : word;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r  <= s4_nxt;
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v4_r <= norm_valid;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_packed_result = res_r;

endmodule

FILE: tb/fanr_tb_pkg.sv
`timescale 1ns / 100ps

package fanr_tb_pkg;
  import fanr_pkg::*;

  class fp_round_scoreboard;
    logic [FW_W-1:0]       fw;
    logic [BIAS_W-1:0]     bias;
    logic [ALL_ONES_W-1:0] all_ones;
    logic [EW_W-1:0]       ew;
    logic [OUT_W-1:0]      packed_q[$];
    int                    noted;
    int                    checked;
    int                    failures;

    function new();
      fw       = FW_RESET;
      bias     = BIAS_RESET;
      all_ones = ALL_ONES_RESET;
      ew       = EW_RESET;
      noted    = 0;
      checked  = 0;
      failures = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_FRACTION_WIDTH:    fw       = value[FW_W-1:0];
        REG_EXPONENT_BIAS:     bias     = value[BIAS_W-1:0];
        REG_EXPONENT_ALL_ONES: all_ones = value[ALL_ONES_W-1:0];
        REG_EXPONENT_WIDTH:    ew       = value[EW_W-1:0];
        default: ;
      endcase
    endfunction

    function int frac_bits();
      if (fw < FW_MIN) return FW_MIN;
      if (fw > FW_MAX) return FW_MAX;
      return int'(fw);
    endfunction

    function logic [63:0] sticky_shift(logic [63:0] m, int n);
      if (n <= 0) return m;
      if (n >= 64) return {63'd0, |m};
      return (m >> n) | {63'd0, |(m & ((64'd1 << n) - 64'd1))};
    endfunction

    function logic [OUT_W-1:0] round_pack(logic zero, logic sign,
                                          logic signed [IN_EXP_W-1:0] sum_exp,
                                          logic [IN_MANT_W-1:0] sum_mant);
      int          fwid;
      int          e;
      int          emin;
      int          raw;
      logic [63:0] m;
      logic [63:0] nmin;
      logic [63:0] nmax;
      logic [63:0] r;
      logic [63:0] rbits;
      logic [63:0] half_ulp;
      logic [63:0] bexp;
      logic [63:0] frac;
      logic [63:0] word;
      if (zero) return '0;
      fwid = frac_bits();
      e    = int'(sum_exp);
      m    = sum_mant;
      emin = 1 - int'(bias);
      nmin = 64'd1 << (fwid + GUARD_BITS);
      nmax = nmin << 1;
      while (m >= nmax) begin
        m = sticky_shift(m, 1);
        e++;
      end
      if (m == 64'd0) begin
        if (e > emin) e = emin;
      end else begin
        while (m < nmin && e > emin) begin
          m = m << 1;
          e--;
        end
      end
      if (e < emin) begin
        m = sticky_shift(m, emin - e);
        e = emin;
      end
      rbits    = m & ((64'd1 << GUARD_BITS) - 64'd1);
      r        = m >> GUARD_BITS;
      half_ulp = 64'd1 << (GUARD_BITS - 1);
      if (rbits > half_ulp || (rbits == half_ulp && r[0])) r = r + 64'd1;
      if (r >= (64'd1 << (fwid + 1))) begin
        r = r >> 1;
        e++;
      end
      raw = e + int'(bias);
      if (raw >= int'(all_ones)) begin
        bexp = 64'(all_ones);
        frac = 64'd0;
      end else if (raw <= 0 || r < (64'd1 << fwid)) begin
        bexp = 64'd0;
        frac = r;
      end else begin
        bexp = 64'(raw);
        frac = r - (64'd1 << fwid);
      end
      word = (frac & ((64'd1 << fwid) - 64'd1)) |
             ((bexp & ((64'd1 << ew) - 64'd1)) << fwid);
      if (fwid + int'(ew) < 64) word = word | ({63'd0, sign} << (fwid + int'(ew)));
      return word;
    endfunction

    function void note_operand(logic zero, logic sign, logic [IN_EXP_W-1:0] sum_exp,
                               logic [IN_MANT_W-1:0] sum_mant);
      noted++;
      packed_q.push_back(round_pack(zero, sign, sum_exp, sum_mant));
    endfunction

    function void check_result(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      checked++;
      if (packed_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("result %h arrived with nothing outstanding", got);
        return;
      end
      want = packed_q.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("packed_result mismatch at result %0d: expected %h, got %h",
                   checked, want, got);
      end
    endfunction

    function int pending();
      return packed_q.size();
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fanr_pkg::*;
  import fanr_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 170;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_is_zero;
  logic                 in_sum_sign;
  logic [IN_EXP_W-1:0]  in_sum_exponent;
  logic [IN_MANT_W-1:0] in_sum_mantissa;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_W-1:0]     out_packed_result;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [CFG_AW-1:0]    cfg_paddr;
  logic [CFG_DW-1:0]    cfg_pwdata;
  logic [CFG_DW-1:0]    cfg_prdata;
  logic                 cfg_pready;

  fp_round_scoreboard sb = new();
  int  cycles = 0;
  int  tx_max_gap = 0;
  int  rx_max_gap = 0;
  int  settings = 1;
  bit  hold_req = 1'b0;

  fp_add_normalize_round_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_is_zero        (in_is_zero),
    .in_sum_sign       (in_sum_sign),
    .in_sum_exponent   (in_sum_exponent),
    .in_sum_mantissa   (in_sum_mantissa),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packed_result (out_packed_result),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_operand(in_is_zero, in_sum_sign, in_sum_exponent, in_sum_mantissa);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_packed_result);
  end

  initial begin
    int n;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = $urandom_range(0, rx_max_gap);
      if (hold_req) begin
        n = n + LONG_HOLD;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk);
  endtask

  task automatic send_operand(logic zero, logic sign, int sexp, logic [IN_MANT_W-1:0] mant);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_is_zero      <= zero;
    in_sum_sign     <= sign;
    in_sum_exponent <= sexp[IN_EXP_W-1:0];
    in_sum_mantissa <= mant;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_operand();
    int          fwc;
    int          p;
    int          lo;
    int          hi;
    int          e;
    logic        zero;
    logic [63:0] mant;
    fwc  = sb.frac_bits();
    zero = ($urandom_range(0, 19) == 0);
    mant = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: mant = 64'($urandom_range(0, 3));
      default: begin
        if ($urandom_range(0, 3) == 0) p = int'($urandom_range(0, 63));
        else p = fwc + GUARD_BITS + int'($urandom_range(0, 6)) - 3;
        if (p > 63) p = 63;
        if (p < 63) mant = mant & ((64'd1 << (p + 1)) - 64'd1);
        mant[p] = 1'b1;
        // force an exact halfway pattern below the rounding point
        if ($urandom_range(0, 4) == 0 && p > fwc) begin
          mant = mant & ~((64'd1 << (p - fwc)) - 64'd1);
          mant[p - fwc - 1] = 1'b1;
        end
      end
    endcase
    lo = 1 - int'(sb.bias) - fwc - 8;
    hi = int'(sb.all_ones) - int'(sb.bias) + 3;
    if ($urandom_range(0, 7) == 0) e = int'($urandom_range(0, 8191)) - 4096;
    else e = lo + int'($urandom_range(0, hi - lo));
    if (e < -4096) e = -4096;
    if (e > 4095) e = 4095;
    send_operand(zero, 1'($urandom), e, mant);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int fw, int bias, int all_ones, int ew,
                           int tx_max, int rx_max, bit pressure);
    drain();
    cfg_write(REG_FRACTION_WIDTH, CFG_DW'(fw));
    cfg_write(REG_EXPONENT_BIAS, CFG_DW'(bias));
    cfg_write(REG_EXPONENT_ALL_ONES, CFG_DW'(all_ones));
    cfg_write(REG_EXPONENT_WIDTH, CFG_DW'(ew));
    settings++;
    tx_max_gap = tx_max;
    rx_max_gap = rx_max;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (pressure && i == 20) hold_req = 1'b1;
      if (pressure && i == 100) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      send_random_operand();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_is_zero      <= 1'b0;
    in_sum_sign     <= 1'b0;
    in_sum_exponent <= '0;
    in_sum_mantissa <= '0;
    out_stall       <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_max_gap = 2;
    rx_max_gap = 2;
    send_operand(1'b1, 1'b1, 4095, '1);
    send_operand(1'b1, 1'b0, -4096, 64'd0);
    send_operand(1'b0, 1'b1, 0, 64'd0);
    send_operand(1'b0, 1'b0, 0, 64'd1 << 55);
    send_operand(1'b0, 1'b0, 1023, 64'd1 << 55);
    send_operand(1'b0, 1'b1, 1024, 64'd1 << 55);
    send_operand(1'b0, 1'b1, 4095, '1);
    send_operand(1'b0, 1'b0, -4096, '1);
    send_operand(1'b0, 1'b0, 0, (64'd1 << 56) - 64'd1);
    send_operand(1'b0, 1'b1, 1023, (64'd1 << 56) - 64'd1);
    send_operand(1'b0, 1'b0, 0, (64'd1 << 55) | 64'd4);
    send_operand(1'b0, 1'b0, 0, (64'd1 << 55) | 64'd12);
    send_operand(1'b0, 1'b1, 0, (64'd1 << 55) | 64'd5);
    send_operand(1'b0, 1'b0, 0, 64'd1);
    send_operand(1'b0, 1'b0, -1022, 64'd1 << 55);
    send_operand(1'b0, 1'b1, -1023, 64'd1 << 55);
    send_operand(1'b0, 1'b0, -1074, 64'd1 << 55);
    send_operand(1'b0, 1'b0, -1075, 64'd1 << 55);
    send_operand(1'b0, 1'b1, -1075, (64'd1 << 55) | 64'd1);
    send_operand(1'b0, 1'b0, -1023, (64'd1 << 56) - 64'd1);
    send_operand(1'b0, 1'b0, -8, 64'h8000_0000_0000_0000);
    send_operand(1'b0, 1'b1, 100, 64'h5555_5555_5555_5555);
    send_operand(1'b0, 1'b0, -1030, 64'hAAAA_AAAA_AAAA_AAAA);

    run_phase(52, 1023, 2047, 11, 0, 0, 1'b0);
    run_phase(23, 127, 255, 8, 1, 16, 1'b1);
    run_phase(10, 15, 31, 5, 16, 0, 1'b0);
    run_phase(1, 1, 3, 2, 4, 4, 1'b0);
    run_phase(0, 0, 3, 15, 16, 16, 1'b0);
    run_phase(63, 1023, 2047, 15, 0, 3, 1'b0);
    run_phase(7, 1023, 2047, 3, 3, 0, 1'b0);
    run_phase(52, 1, 2047, 11, 8, 8, 1'b0);
    for (int k = 0; k < 4; k++)
      run_phase($urandom_range(1, 52), $urandom_range(1, 1023), $urandom_range(3, 2047),
                $urandom_range(2, 11), $urandom_range(0, 16), $urandom_range(0, 16), 1'b0);

    drain();
    $display("Ran %0d transactions through %0d register settings, %0d results checked.",
             sb.noted, settings, sb.checked);
    $display("Covered zeros, rounding ties, carries, overflow, subnormals and format edges.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
